// ===== rtl/core/swmc_pkg.sv =====
package swmc_pkg;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int SAMPLE_W        = 32;
    localparam int COST_W          = 38;
    localparam int LEN_W           = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd3;

    typedef struct packed {
        logic clear;     // empty window (length write)
        logic load;      // latch incoming sample, start step
        logic restart;   // empty window before this sample
        logic evict;     // remove pass
        logic insert;    // insert pass
        logic median;    // fetch median, set up accumulate
        logic acc;       // accumulate pass
        logic first;     // first cycle of a pass
    } swmc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic full;
    } swmc_sts_t;
endpackage

// ===== rtl/core/swmc_datapath.sv =====
module swmc_datapath
    import swmc_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  swmc_cmd_t           cmd,
    input  logic [LEN_W-1:0]    window_len,
    input  logic [SAMPLE_W-1:0] sample,
    output swmc_sts_t           sts,
    output logic [COST_W-1:0]   cost,
    output logic [SAMPLE_W-1:0] median
);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int DW = SAMPLE_BITS + 1;

    // sorted cells: one registered read and one write per cycle
    logic signed [SAMPLE_BITS-1:0] cell_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_reg, oldest_reg, new_reg, med_reg;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] slot_reg;
    logic          found_reg;
    logic [COST_W-1:0] cost_reg;
    logic [CW-1:0] k;
    logic [CW-1:0] mid;
    logic [IW-1:0] slot_eff, slot_wrap, rd_addr, wr_addr;
    logic          match, shift, wr_en;
    logic signed [DW-1:0] diff;

    always_comb
    begin
        if (window_len == '0)
            k = CW'(1);
        else if (32'(window_len) > MAX_WINDOW)
            k = CW'(MAX_WINDOW);
        else
            k = CW'(window_len);
        mid       = CW'((k - CW'(1)) >> 1);
        slot_eff  = (CW'(slot_reg) >= k) ? '0 : slot_reg;
        slot_wrap = (CW'(slot_reg) + CW'(1) >= k) ? '0 : slot_reg + IW'(1);
    end

    // rd_reg holds cell[idx_reg] (evict, acc) or cell[idx_reg-1] (insert)
    assign match = (rd_reg == oldest_reg);
    assign shift = (idx_reg != '0) && (rd_reg > new_reg);

    always_comb
    begin
        rd_addr = '0;
        if (cmd.evict)
            rd_addr = cmd.first ? '0 : IW'(idx_reg + CW'(1));
        else if (cmd.insert)
            rd_addr = cmd.first ? IW'(fill_reg - CW'(1)) : IW'(idx_reg - CW'(2));
        else if (cmd.median)
            rd_addr = cmd.first ? IW'(mid) : '0;
        else if (cmd.acc)
            rd_addr = IW'(idx_reg + CW'(1));
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_reg;
        if (cmd.evict && !cmd.first && found_reg)
        begin
            // pull cell down over the removed one
            wr_en   = 1'b1;
            wr_addr = IW'(idx_reg - CW'(1));
        end
        else if (cmd.insert && !cmd.first)
        begin
            wr_en   = 1'b1;
            wr_addr = IW'(idx_reg);
            wr_data = shift ? rd_reg : new_reg;
        end
    end

    assign sts.full      = (fill_reg >= k);
    assign sts.scan_done = cmd.insert ? !shift
                         : cmd.acc    ? (idx_reg == k - CW'(1))
                                      : (idx_reg == fill_reg - CW'(1));

    always_comb
    begin
        if (idx_reg < mid)
            diff = DW'(med_reg) - DW'(rd_reg);
        else
            diff = DW'(rd_reg) - DW'(med_reg);
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= cell_mem[rd_addr];
        if (wr_en)
            cell_mem[wr_addr] <= wr_data;
        if (cmd.load)
        begin
            oldest_reg <= ring_mem[slot_eff];
            new_reg    <= $signed(sample[SAMPLE_BITS-1:0]);
        end
        if (cmd.insert && cmd.first)
            ring_mem[slot_reg] <= new_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            slot_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            med_reg   <= '0;
            cost_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                fill_reg <= '0;
                slot_reg <= '0;
            end
            else if (cmd.load)
            begin
                if (cmd.restart)
                begin
                    fill_reg <= '0;
                    slot_reg <= '0;
                end
                else
                    slot_reg <= slot_eff;
            end
            else if (cmd.evict)
            begin
                // walk cells upward; after the match every cell moves down one
                if (cmd.first)
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                else
                begin
                    if (match)
                        found_reg <= 1'b1;
                    if (idx_reg == fill_reg - CW'(1) && (found_reg || match))
                        fill_reg <= fill_reg - CW'(1);
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            else if (cmd.insert)
            begin
                // walk from the top down; larger cells move up one
                if (cmd.first)
                begin
                    idx_reg  <= fill_reg;
                    slot_reg <= slot_wrap;
                end
                else if (shift)
                    idx_reg <= idx_reg - CW'(1);
                else
                    fill_reg <= fill_reg + CW'(1);
            end
            else if (cmd.median)
            begin
                if (!cmd.first)
                begin
                    med_reg  <= rd_reg;
                    cost_reg <= '0;
                    idx_reg  <= '0;
                end
            end
            else if (cmd.acc)
            begin
                cost_reg <= cost_reg + COST_W'(unsigned'(diff));
                idx_reg  <= idx_reg + CW'(1);
            end
        end
    end

    assign cost   = cost_reg;
    assign median = SAMPLE_W'(med_reg);
endmodule

// ===== rtl/core/swmc_ctrl.sv =====
module swmc_ctrl
    import swmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_restart,
    output logic      in_ready,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  swmc_sts_t sts,
    output swmc_cmd_t cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_EV0, S_EV, S_IN0, S_IN, S_MED0, S_MED, S_AC
    } state_t;
    state_t state_reg;
    logic   out_valid_reg;
    logic   idle;
    logic   take;

    // length write wins over a sample offered in the same cycle
    assign idle      = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = idle;
    assign in_ready  = idle && !cfg_valid;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.clear   = cfg_valid && idle;
        cmd.load    = take;
        cmd.restart = take && in_restart;
        case (state_reg)
            S_EV0:
            begin
                cmd.evict = 1'b1;
                cmd.first = 1'b1;
            end
            S_EV:   cmd.evict = 1'b1;
            S_IN0:
            begin
                cmd.insert = 1'b1;
                cmd.first  = 1'b1;
            end
            S_IN:   cmd.insert = 1'b1;
            S_MED0:
            begin
                cmd.median = 1'b1;
                cmd.first  = 1'b1;
            end
            S_MED:  cmd.median = 1'b1;
            S_AC:   cmd.acc = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (take) state_reg <= S_EV0;
                S_EV0:  state_reg <= sts.full ? S_EV : S_IN0;
                S_EV:   if (sts.scan_done) state_reg <= S_IN0;
                S_IN0:  state_reg <= S_IN;
                S_IN:   if (sts.scan_done) state_reg <= S_MED0;
                S_MED0: state_reg <= sts.full ? S_MED : S_IDLE;
                S_MED:  state_reg <= S_AC;
                S_AC:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/sliding_window_median_cost_unit.sv =====
// Sliding-window median cost. Each accepted word carries one signed sample;
// the unit keeps the last k samples, k being window_len clamped to
// 1..MAX_WINDOW, in arrival order and in ascending order. Once the window
// is full, every sample yields one output word: the lower median and the
// sum of absolute deviations from it. The sorted cells sit in a RAM walked
// one cell per cycle. Each sample runs an evict walk (only with a full
// window), an insert walk that stops where the new sample settles, a median
// fetch and, with a full window, an accumulate walk over all k cells.
// A new sample is taken only when idle and no output word is pending.
// A restart bit empties the window; writing window_len does too, and the
// write is held off until the unit is idle.
module sliding_window_median_cost_unit
    import swmc_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // cost[37:0], median[69:38], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    logic [LEN_W-1:0]  len_reg;
    swmc_cmd_t         cmd;
    swmc_sts_t         sts;
    logic [COST_W-1:0] cost;
    logic [SAMPLE_W-1:0] median;
    logic              cfg_wr;

    // window length register; accepted only while idle
    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= LEN_RESET;
        else if (cfg_wr)
            len_reg <= cfg_data;
    end

    swmc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_restart(s_tuser), .in_ready(s_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    swmc_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .window_len(len_reg),
        .sample(s_tdata), .sts(sts), .cost(cost), .median(median)
    );

    // result registers hold until the output word is taken
    assign m_tdata = {2'b00, median, cost};
endmodule

// ===== rtl/core/swmc_checker.sv =====
module swmc_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [71:0] m_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("out dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("out moved");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("second sample taken");
    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("took while result pending");
endmodule

bind sliding_window_median_cost_unit swmc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== verif/tb.sv =====
module tb
    import swmc_pkg::*;
();

    localparam int WIN_MAX    = MAX_WINDOW_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // sample
    logic        s_tuser;   // restart
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // cost[37:0], median[69:38], zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [SAMPLE_W-1:0] median;
    } mad_word_t;

    int err_count;

    task automatic report_err(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // Median-cost predictor plus queue of expected output words.
    class mad_scoreboard;
        logic signed [SAMPLE_W-1:0] ring [WIN_MAX];
        logic signed [SAMPLE_W-1:0] sorted [WIN_MAX];
        int unsigned fill;
        int unsigned slot;
        logic [LEN_W-1:0] win_len;
        mad_word_t pending[$];
        int words_seen;

        function void clear_state(logic [LEN_W-1:0] len);
            win_len = len;
            fill = 0;
            slot = 0;
        endfunction

        function int unsigned eff_len();
            if (win_len == 0) return 1;
            if (win_len > WIN_MAX) return WIN_MAX;
            return 32'(win_len);
        endfunction

        function void drop_value(logic signed [SAMPLE_W-1:0] v);
            int unsigned pos;
            pos = fill;
            for (int unsigned i = 0; i < fill; i++)
                if (sorted[i] == v) begin
                    pos = i;
                    break;
                end
            if (pos >= fill) return;
            for (int unsigned i = pos; i + 1 < fill; i++)
                sorted[i] = sorted[i+1];
            fill--;
        endfunction

        function void add_value(logic signed [SAMPLE_W-1:0] v);
            int unsigned i;
            i = fill;
            if (fill >= WIN_MAX) return;
            while (i > 0 && sorted[i-1] > v) begin
                sorted[i] = sorted[i-1];
                i--;
            end
            sorted[i] = v;
            fill++;
        endfunction

        // Called once per accepted sample word.
        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
            int unsigned k;
            int unsigned mid;
            logic signed [63:0] med;
            logic [63:0] acc;
            mad_word_t w;
            k = eff_len();
            if (restart) begin
                fill = 0;
                slot = 0;
            end
            if (slot >= k) slot = 0;
            if (fill >= k) drop_value(ring[slot]);
            add_value(s);
            ring[slot] = s;
            slot = (slot + 1 >= k) ? 0 : slot + 1;
            if (fill < k) return;
            mid = (k - 1) / 2;
            med = sorted[mid];
            acc = 0;
            for (int unsigned i = 0; i < k; i++)
                if (i < mid) acc += med - 64'(sorted[i]);
                else         acc += 64'(sorted[i]) - med;
            w.cost   = acc[COST_W-1:0];
            w.median = med[SAMPLE_W-1:0];
            pending = {pending, w};
        endfunction

        task check_word(logic [71:0] data);
            mad_word_t want;
            words_seen++;
            if (pending.size() == 0) begin
                report_err("output word with nothing expected", 64'(0), 64'(0));
                return;
            end
            want = pending.pop_front();
            if (data[37:0] !== want.cost)
                report_err("cost", 64'(data[37:0]), 64'(want.cost));
            if (data[69:38] !== want.median)
                report_err("median", 64'(data[69:38]), 64'(want.median));
            if (data[71:70] !== 2'b00)
                report_err("pad bits", 64'(data[71:70]), 64'(0));
        endtask
    endclass

    mad_scoreboard sb;
    int idle_cycles;
    int samples_sent;
    int windows_used;

    sliding_window_median_cost_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Monitor: note accepted samples, check output words, watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stall per word, with a stall-free stretch.
    bit rx_fast;
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever begin
            gap = rx_fast ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    bit tx_fast;

    task automatic send_sample(logic [31:0] s, logic restart);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        // Samples that fill the window give no word; wait until idle.
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_len(logic [6:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.clear_state(len);
        windows_used++;
    endtask

    function automatic logic [31:0] rand_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20)) - 10);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 3));  // many duplicates
        endcase
    endfunction

    initial
    begin
        logic [6:0] lens [];
        int per_len;
        lens = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd5, 7'd4, 7'd17};
        sb = new();
        sb.clear_state(LEN_RESET);
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset length 3, extremes, duplicates, restart mid-window.
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0005, 1'b1);   // restart empties the window
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'hffff_fffb, 1'b0);
        write_len(7'd1);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        write_len(7'd2);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        write_len(7'd64);
        for (int i = 0; i < 64; i++)
            send_sample(i[0] ? 32'h7fff_ffff : 32'h8000_0000, 1'b0);

        // Random: lengths cycle through extremes; mostly full-window runs.
        per_len = 1250 / lens.size();
        foreach (lens[j]) begin
            write_len(lens[j]);
            tx_fast = (j == 3);
            rx_fast = (j == 3);
            for (int i = 0; i < per_len; i++) begin
                if (i == per_len / 2) drain();     // sender waits for all words
                send_sample(rand_sample($urandom_range(0, 3)),
                            ($urandom_range(0, 99) == 0));
            end
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;

        drain();
        $display("sent %0d samples over %0d window settings, checked %0d words",
                 samples_sent, windows_used, sb.words_seen);
        if (err_count == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/swmc_pkg.sv
rtl/core/swmc_datapath.sv
rtl/core/swmc_ctrl.sv
rtl/core/sliding_window_median_cost_unit.sv
rtl/core/swmc_checker.sv
verif/tb.sv
